// File: design/lrev_pkg.sv
// Shared types, constants and tables of the line ring escape vector block.
`default_nettype none
package lrev_pkg;

	localparam int SENSORS = 32;
	localparam int ANG_W = 13;
	localparam int FULL_TURN = 5760;
	localparam int HALF_TURN = 2880;
	localparam int SUM_W = 20;
	localparam int CW = 26;
	localparam int ZW = 23;
	localparam int ATAN_LEN = 18;
	localparam logic [31:0] MASK_RIGHT = 32'h001FF000;
	localparam logic [31:0] MASK_LEFT = 32'hF000001F;
	localparam logic [1:0] REG_THRESH = 2'd0;
	localparam logic [1:0] REG_SPEED = 2'd1;
	localparam logic [1:0] REG_CORNER = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VEC,
		ST_HEAD,
		ST_ROT,
		ST_OUT
	} bk_state_t;

	// Classified item handed from the front part to the back part.
	typedef struct packed {
		logic signed [SUM_W-1:0] sx;
		logic signed [SUM_W-1:0] sy;
		logic outer;
		logic mid;
		logic corner;
	} item_t;

	typedef struct packed {
		logic line_found;
		logic signed [15:0] vel_x;
		logic signed [15:0] vel_y;
		logic past_half;
		logic mid_line_seen;
	} result_t;

	// Q14 sine of i * 11.25 degrees around the ring.
	function automatic logic signed [15:0] ring_sin(input logic [4:0] i);
		logic [15:0] q;
		logic [3:0] k;
		begin
			if (i <= 5'd8) k = i[3:0];
			else if (i <= 5'd16) k = 4'(5'd16 - i);
			else if (i <= 5'd24) k = 4'(i - 5'd16);
			else k = 4'(6'd32 - {1'b0, i});
			case (k)
				4'd0: q = 16'd0;
				4'd1: q = 16'd3196;
				4'd2: q = 16'd6270;
				4'd3: q = 16'd9102;
				4'd4: q = 16'd11585;
				4'd5: q = 16'd13623;
				4'd6: q = 16'd15137;
				4'd7: q = 16'd16069;
				default: q = 16'd16384;
			endcase
			ring_sin = (i > 5'd16) ? -$signed(q) : $signed(q);
		end
	endfunction

	// Arctangent of 2^-i in 1/4096 degree.
	function automatic logic [ZW-1:0] atan_val(input logic [4:0] i);
		case (i)
			5'd0: atan_val = 23'd184320;
			5'd1: atan_val = 23'd108810;
			5'd2: atan_val = 23'd57492;
			5'd3: atan_val = 23'd29184;
			5'd4: atan_val = 23'd14649;
			5'd5: atan_val = 23'd7331;
			5'd6: atan_val = 23'd3667;
			5'd7: atan_val = 23'd1833;
			5'd8: atan_val = 23'd917;
			5'd9: atan_val = 23'd458;
			5'd10: atan_val = 23'd229;
			5'd11: atan_val = 23'd115;
			5'd12: atan_val = 23'd57;
			5'd13: atan_val = 23'd29;
			5'd14: atan_val = 23'd14;
			5'd15: atan_val = 23'd7;
			5'd16: atan_val = 23'd4;
			5'd17: atan_val = 23'd2;
			default: atan_val = 23'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: design/lrev_front.sv
// Front part: accepts sensor snapshots, sums unit vectors and queues the items.
`default_nettype none
module lrev_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [31:0] bits_in,
	input wire logic front_inside,
	output logic item_valid,
	input wire logic item_ready,
	output lrev_pkg::item_t item
);

	logic [31:0] bits_q;
	logic front_q;
	logic busy_q;
	logic [4:0] idx_q;
	logic signed [lrev_pkg::SUM_W-1:0] sx_q, sy_q;
	logic outer_q, mid_q;
	lrev_pkg::item_t fifo_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push;
	logic pop;
	logic cur_active, cur_mid;
	logic right, left;
	lrev_pkg::item_t done_item;

	assign in_ready = !busy_q;
	assign cur_active = !bits_q[idx_q];
	assign cur_mid = idx_q >= 5'd6 && idx_q <= 5'd10;
	assign right = (bits_q & lrev_pkg::MASK_RIGHT) != lrev_pkg::MASK_RIGHT;
	assign left = (bits_q & lrev_pkg::MASK_LEFT) != lrev_pkg::MASK_LEFT;
	assign push = busy_q && idx_q == 5'd31 && cnt_q != 2'd2;
	assign pop = item_valid && item_ready;
	assign item_valid = cnt_q != 2'd0;
	assign item = fifo_q[rp_q];

	// Final sum includes the last sensor, which is never a mid sensor.
	always_comb begin
		done_item.sx = sx_q;
		done_item.sy = sy_q;
		done_item.outer = outer_q || cur_active;
		done_item.mid = mid_q;
		done_item.corner = (right != left) && !front_q;
		if (cur_active) begin
			done_item.sx = sx_q + lrev_pkg::SUM_W'(lrev_pkg::ring_sin(5'(idx_q + 5'd8)));
			done_item.sy = sy_q + lrev_pkg::SUM_W'(lrev_pkg::ring_sin(idx_q));
		end
	end

	// One sensor is taken per cycle; the last waits for room in the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end
		end else if (idx_q != 5'd31) begin
			idx_q <= idx_q + 5'd1;
		end else if (push) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			bits_q <= bits_in;
			front_q <= front_inside;
			sx_q <= '0;
			sy_q <= '0;
			outer_q <= 1'b0;
			mid_q <= 1'b0;
		end else if (idx_q != 5'd31 && cur_active) begin
			if (cur_mid) begin
				mid_q <= 1'b1;
			end else begin
				sx_q <= done_item.sx;
				sy_q <= done_item.sy;
				outer_q <= 1'b1;
			end
		end
	end

	// Two-entry queue toward the back part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= done_item;
	end

endmodule
`default_nettype wire

// File: design/lrev_back.sv
// Back part: CORDIC angle, drift check, heading snap and velocity rotation.
`default_nettype none
module lrev_back #(
	parameter int CORDIC_STEPS = 14
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input lrev_pkg::item_t item,
	input wire logic [7:0] thresh,
	input wire logic [6:0] speed,
	input wire logic [6:0] corner_vy,
	output logic res_valid,
	input wire logic res_ready,
	output lrev_pkg::result_t res
);

	localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);
	localparam int CW = lrev_pkg::CW;
	localparam int ZW = lrev_pkg::ZW;
	localparam logic signed [ZW-1:0] FULL_Z = ZW'(lrev_pkg::FULL_TURN * 256);
	localparam logic signed [ZW-1:0] HALF_Z = ZW'(lrev_pkg::HALF_TURN * 256);

	lrev_pkg::bk_state_t state_q, state_d;
	logic [4:0] i_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;
	lrev_pkg::item_t it_q;
	logic first_q;
	logic [lrev_pkg::ANG_W-1:0] init_q;
	logic flip_q, past_q;
	logic signed [CW-1:0] dx, dy;
	logic dir;
	logic signed [ZW-1:0] at;
	logic signed [ZW-1:0] zn;
	logic [ZW-1:0] zr;
	logic [lrev_pkg::ANG_W-1:0] ang, ref_ang, diff, head0, head1;
	logic [13:0] hsum;
	logic past;
	logic signed [CW-1:0] fx, fy, rx, ry;

	assign item_ready = state_q == lrev_pkg::ST_IDLE && !res_valid;
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed(lrev_pkg::atan_val(i_q));
	// Vectoring turns toward y = 0; rotation turns z toward 0.
	assign dir = (state_q == lrev_pkg::ST_VEC) ? (y_q > 0) : (z_q >= 0);

	// Angle of the vector in 1/16 degree; a zero sum stays zero through the
	// vectoring steps and gives angle 0.
	always_comb begin
		zn = z_q;
		if (zn < 0) zn = zn + FULL_Z;
		zr = ZW'(zn) + ZW'(128);
		ang = 13'(zr >> 8);
		if (x_q == 0 && y_q == 0) ang = '0;
		if (ang >= 13'(lrev_pkg::FULL_TURN)) ang = ang - 13'(lrev_pkg::FULL_TURN);
		ref_ang = first_q ? init_q : ang;
		diff = (ang >= ref_ang) ? ang - ref_ang : ref_ang - ang;
		if (diff > 13'(lrev_pkg::HALF_TURN)) diff = 13'(lrev_pkg::FULL_TURN) - diff;
		past = diff > {1'b0, thresh, 4'd0};
		hsum = (past ? {1'b0, ref_ang} : {1'b0, ang}) + 14'(lrev_pkg::HALF_TURN);
		head0 = (hsum >= 14'(lrev_pkg::FULL_TURN)) ? 13'(hsum - 14'(lrev_pkg::FULL_TURN))
			: 13'(hsum);
		head1 = head0;
		if (head0 >= 13'd720 && head0 < 13'd2160) head1 = 13'd1440;
		else if (head0 >= 13'd2160 && head0 < 13'd3600) head1 = 13'd2880;
	end

	// Rounded outputs of the rotation.
	always_comb begin
		fx = flip_q ? -x_q : x_q;
		fy = flip_q ? -y_q : y_q;
		rx = (fx + CW'(128)) >>> 8;
		ry = (fy + CW'(256)) >>> 9;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lrev_pkg::ST_IDLE: if (item_valid && item_ready) begin
				state_d = item.outer ? lrev_pkg::ST_VEC : lrev_pkg::ST_OUT;
			end
			lrev_pkg::ST_VEC: if (i_q == LAST) state_d = lrev_pkg::ST_HEAD;
			lrev_pkg::ST_HEAD: state_d = lrev_pkg::ST_ROT;
			lrev_pkg::ST_ROT: if (i_q == LAST) state_d = lrev_pkg::ST_OUT;
			lrev_pkg::ST_OUT: state_d = lrev_pkg::ST_IDLE;
			default: state_d = lrev_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrev_pkg::ST_IDLE;
			i_q <= '0;
			first_q <= 1'b0;
			init_q <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_valid && res_ready) res_valid <= 1'b0;
			case (state_q)
				lrev_pkg::ST_IDLE: i_q <= '0;
				lrev_pkg::ST_VEC: i_q <= (i_q == LAST) ? 5'd0 : i_q + 5'd1;
				lrev_pkg::ST_HEAD: begin
					i_q <= '0;
					if (!first_q) begin
						first_q <= 1'b1;
						init_q <= ang;
					end
				end
				lrev_pkg::ST_ROT: i_q <= i_q + 5'd1;
				lrev_pkg::ST_OUT: begin
					res_valid <= 1'b1;
					if (!it_q.outer) first_q <= 1'b0;
				end
				default: i_q <= '0;
			endcase
		end
	end

	// Datapath of the shared CORDIC unit.
	always_ff @(posedge clk) begin
		case (state_q)
			lrev_pkg::ST_IDLE: begin
				it_q <= item;
				past_q <= 1'b0;
				flip_q <= 1'b0;
				if (item.sx < 0) begin
					x_q <= -CW'(item.sx);
					y_q <= -CW'(item.sy);
					z_q <= HALF_Z;
				end else begin
					x_q <= CW'(item.sx);
					y_q <= CW'(item.sy);
					z_q <= '0;
				end
			end
			lrev_pkg::ST_VEC, lrev_pkg::ST_ROT: begin
				if (dir) begin
					x_q <= (state_q == lrev_pkg::ST_VEC) ? x_q + dx : x_q - dx;
					y_q <= (state_q == lrev_pkg::ST_VEC) ? y_q - dy : y_q + dy;
					z_q <= (state_q == lrev_pkg::ST_VEC) ? z_q + at : z_q - at;
				end else begin
					x_q <= (state_q == lrev_pkg::ST_VEC) ? x_q - dx : x_q + dx;
					y_q <= (state_q == lrev_pkg::ST_VEC) ? y_q + dy : y_q - dy;
					z_q <= (state_q == lrev_pkg::ST_VEC) ? z_q - at : z_q + at;
				end
			end
			lrev_pkg::ST_HEAD: begin
				past_q <= past;
				flip_q <= head1 > 13'd1440 && head1 < 13'd4320;
				x_q <= CW'(speed) * CW'(39797);
				y_q <= '0;
				if (head1 > 13'd1440 && head1 < 13'd4320)
					z_q <= $signed({2'b0, head1, 8'd0}) - HALF_Z;
				else if (head1 >= 13'd4320)
					z_q <= $signed({2'b0, head1, 8'd0}) - FULL_Z;
				else
					z_q <= $signed({2'b0, head1, 8'd0});
			end
			lrev_pkg::ST_OUT: begin
				res.line_found <= it_q.outer;
				res.mid_line_seen <= it_q.mid;
				res.past_half <= it_q.outer && past_q;
				res.vel_x <= it_q.outer ? 16'(rx) : '0;
				if (!it_q.outer) res.vel_y <= '0;
				else if (it_q.corner) res.vel_y <= {1'b0, corner_vy, 8'd0};
				else res.vel_y <= 16'(ry);
			end
			default: x_q <= x_q;
		endcase
	end

endmodule
`default_nettype wire

// File: design/line_ring_escape_vector_top.sv
// Top level of the line ring escape vector block.
// One result per sensor snapshot. The front part accepts a snapshot, folds the
// ring one sensor per cycle (the last waits while the queue is full) and queues
// the item; the back part runs one shared CORDIC for CORDIC_STEPS vectoring
// steps, a heading state and CORDIC_STEPS rotation steps on an item with a line
// and takes an item without one straight to its result state. The parts overlap
// through the queue, so the front part can take a new snapshot while the back
// part still works on the last one. Configuration is to be written by the user
// only while the block is idle; the block does not enforce this. Index 0 is
// threshold, 1 speed, 2 corner y velocity; other indexes are ignored.
`default_nettype none
module line_ring_escape_vector_top #(
	parameter int CORDIC_STEPS = 14
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [31:0] s_tdata, // sensor_bits
	input wire logic s_tuser, // front_inside
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [39:0] m_tdata, // vel_x, vel_y, past_half, mid_line_seen, zeros
	output logic m_tuser, // line_found
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [1:0] cfg_index,
	input wire logic [7:0] cfg_data
);

	logic [7:0] thresh_q;
	logic [6:0] speed_q, corner_q;
	logic item_valid, item_ready;
	lrev_pkg::item_t item;
	lrev_pkg::result_t res;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 8'd90;
			speed_q <= 7'd40;
			corner_q <= 7'd20;
		end else if (cfg_valid) begin
			case (cfg_index)
				lrev_pkg::REG_THRESH: thresh_q <= cfg_data;
				lrev_pkg::REG_SPEED: speed_q <= cfg_data[6:0];
				lrev_pkg::REG_CORNER: corner_q <= cfg_data[6:0];
				default: thresh_q <= thresh_q;
			endcase
		end
	end

	lrev_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.bits_in(s_tdata), .front_inside(s_tuser),
		.item_valid(item_valid), .item_ready(item_ready), .item(item)
	);

	lrev_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.thresh(thresh_q), .speed(speed_q), .corner_vy(corner_q),
		.res_valid(m_tvalid), .res_ready(m_tready), .res(res)
	);

	assign m_tuser = res.line_found;
	assign m_tdata = {6'd0, res.mid_line_seen, res.past_half, res.vel_y, res.vel_x};

endmodule
`default_nettype wire
